// ----- rtl/core/bfi_pkg.sv -----
// bfi_pkg: shared types, constants and the CRC-32 byte update for the Bloom filter insert block.
// No dependencies. Imported by every module in rtl/core.
package bfi_pkg;

   localparam int unsigned CrcWidth    = 32;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned WordWidth   = 64;
   localparam int unsigned FilterWords = 4;
   localparam int unsigned FilterBits  = WordWidth * FilterWords;
   localparam int unsigned HashSlots   = 4;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned SelWidth    = $clog2(FilterWords);
   localparam int unsigned IdxWidth    = $clog2(FilterBits);

   localparam logic [CrcWidth-1:0]   CrcPoly       = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0]   CrcInit       = '1;
   localparam logic [CountWidth-1:0] HashCountRst  = 3'd4;
   localparam logic [CountWidth-1:0] HashCountMax  = 3'd4;

   typedef enum logic [1:0] {
      MODE_BYTE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   // Update request from the top level to the filter store.
   typedef struct packed {
      logic                                 clear;
      logic [HashSlots-1:0]                 set_en;
      logic [HashSlots-1:0][IdxWidth-1:0]   bit_idx;
   } filter_ctl_type;

   // Reflected CRC-32, one byte folded in, eight shift/xor steps.
   function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc,
                                                     input logic [ByteWidth-1:0] data);
      logic [CrcWidth-1:0] c;
      c = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
      for (int n = 0; n < ByteWidth; n++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/bfi_crc.sv -----
// bfi_crc: running CRC-32 register and byte update.
// Depends on bfi_pkg.
module bfi_crc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_en,
   input  logic                         byte_last,
   input  logic [bfi_pkg::ByteWidth-1:0] byte_data,
   output logic [bfi_pkg::CrcWidth-1:0]  crc_final
);
   import bfi_pkg::*;

   logic [CrcWidth-1:0] crc_ff;
   logic [CrcWidth-1:0] crc_in;
   logic [CrcWidth-1:0] crc_next;

   assign crc_next  = crc_byte(crc_ff, byte_data);
   assign crc_final = ~crc_next;

   always_comb begin
      crc_in = crc_ff;
      if (byte_en) begin
         crc_in = byte_last ? CrcInit : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CrcInit;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

// ----- rtl/core/bfi_filter.sv -----
// bfi_filter: 256-bit filter store with bit set, clear and word read.
// Depends on bfi_pkg.
module bfi_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  bfi_pkg::filter_ctl_type        ctl,
   input  logic [bfi_pkg::SelWidth-1:0]   word_sel,
   output logic [bfi_pkg::WordWidth-1:0]  word_data
);
   import bfi_pkg::*;

   logic [FilterWords-1:0][WordWidth-1:0] store_ff;
   logic [FilterWords-1:0][WordWidth-1:0] store_in;

   // read sees the store before this cycle's update
   assign word_data = store_ff[word_sel];

   always_comb begin
      store_in = store_ff;
      if (ctl.clear) begin
         store_in = '0;
      end else begin
         for (int i = 0; i < HashSlots; i++) begin
            if (ctl.set_en[i]) begin
               store_in[ctl.bit_idx[i][IdxWidth-1 -: SelWidth]]
                       [ctl.bit_idx[i][IdxWidth-SelWidth-1:0]] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else begin
         store_ff <= store_in;
      end
   end

endmodule

// ----- rtl/core/bloom_filter_insert_crc32_top.sv -----
// bloom_filter_insert_crc32_top: Bloom filter insert with CRC-32 hashing, top level.
// Depends on bfi_pkg, bfi_crc, bfi_filter.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   req     | in        | req_valid/req_stall  | mode, id_byte, id_last, word_select
//   rsp     | out       | rsp_valid/rsp_stall  | result_kind, hash_value, filter_word
//   csr     | in        | csr_wr_en            | csr_wr_data = hash_count
//
// One item per cycle while no result is stalled. A transfer lands in the input
// register, is processed there (CRC byte update, bit sets, word read) once it
// can advance, and its result then sits in the output register.
// The output register decouples the sides; req_stall rises only when an item
// that yields a result waits behind a stalled result. Reset is synchronous:
// CRC goes to all ones, filter to zeros, hash_count to 4, both stages empty.
module bloom_filter_insert_crc32_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_mode,
   input  logic [bfi_pkg::ByteWidth-1:0]    req_id_byte,
   input  logic                             req_id_last,
   input  logic [bfi_pkg::SelWidth-1:0]     req_word_select,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_result_kind,
   output logic [bfi_pkg::CrcWidth-1:0]     rsp_hash_value,
   output logic [bfi_pkg::WordWidth-1:0]    rsp_filter_word,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [bfi_pkg::CountWidth-1:0]   csr_wr_data
);
   import bfi_pkg::*;

   // hash_count register
   logic [CountWidth-1:0] hash_count_ff;
   logic [CountWidth-1:0] hash_count_in;
   logic [CountWidth-1:0] hash_eff;

   // input stage
   logic                  in_vld_ff, in_vld_in;
   mode_type              in_mode_ff, in_mode_in;
   logic [ByteWidth-1:0]  in_byte_ff, in_byte_in;
   logic                  in_last_ff, in_last_in;
   logic [SelWidth-1:0]   in_sel_ff, in_sel_in;

   // output stage
   logic                  out_vld_ff, out_vld_in;
   kind_type              out_kind_ff, out_kind_in;
   logic [CrcWidth-1:0]   out_hash_ff, out_hash_in;
   logic [WordWidth-1:0]  out_word_ff, out_word_in;

   logic                  req_take;
   logic                  advance;
   logic                  has_result;
   logic                  do_byte;
   logic                  do_insert;
   logic                  do_read;
   logic                  do_clear;
   logic [CrcWidth-1:0]   crc_final;
   logic [WordWidth-1:0]  word_data;
   filter_ctl_type        fctl;

   // ---- decode of the item in the input register ----
   always_comb begin
      do_byte  = 1'b0;
      do_read  = 1'b0;
      do_clear = 1'b0;
      unique case (in_mode_ff)
         MODE_BYTE:  do_byte  = in_vld_ff;
         MODE_READ:  do_read  = in_vld_ff;
         MODE_CLEAR: do_clear = in_vld_ff;
         MODE_NONE:  ;
         default:    ;
      endcase
   end

   assign do_insert  = do_byte && in_last_ff;
   assign has_result = do_insert || do_read;

   // item leaves the input register unless its result would overrun a stalled one
   assign advance   = in_vld_ff && (!has_result || !out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // ---- configuration ----
   assign hash_count_in = csr_wr_en ? csr_wr_data : hash_count_ff;
   assign hash_eff      = (hash_count_ff > HashCountMax) ? HashCountMax : hash_count_ff;

   // ---- CRC and filter ----
   bfi_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (do_byte && advance),
      .byte_last (in_last_ff),
      .byte_data (in_byte_ff),
      .crc_final (crc_final)
   );

   always_comb begin
      fctl.clear = do_clear && advance;
      for (int i = 0; i < HashSlots; i++) begin
         fctl.bit_idx[i] = crc_final[i*ByteWidth +: ByteWidth];
         fctl.set_en[i]  = do_insert && advance && (CountWidth'(i) < hash_eff);
      end
   end

   bfi_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fctl),
      .word_sel  (in_sel_ff),
      .word_data (word_data)
   );

   // ---- input register next state ----
   always_comb begin
      in_vld_in  = in_vld_ff && !advance;
      in_mode_in = in_mode_ff;
      in_byte_in = in_byte_ff;
      in_last_in = in_last_ff;
      in_sel_in  = in_sel_ff;
      if (req_take) begin
         in_vld_in  = 1'b1;
         in_mode_in = mode_type'(req_mode);
         in_byte_in = req_id_byte;
         in_last_in = req_id_last;
         in_sel_in  = req_word_select;
      end
   end

   // ---- output register next state ----
   always_comb begin
      out_vld_in  = out_vld_ff && rsp_stall;
      out_kind_in = out_kind_ff;
      out_hash_in = out_hash_ff;
      out_word_in = out_word_ff;
      if (advance && has_result) begin
         out_vld_in  = 1'b1;
         out_kind_in = do_read ? KIND_READ : KIND_INSERT;
         out_hash_in = do_read ? '0 : crc_final;
         out_word_in = do_read ? word_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_count_ff <= HashCountRst;
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         hash_count_ff <= hash_count_in;
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_mode_ff  <= in_mode_in;
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      in_sel_ff   <= in_sel_in;
      out_kind_ff <= out_kind_in;
      out_hash_ff <= out_hash_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_hash_value  = out_hash_ff;
   assign rsp_filter_word = out_word_ff;

endmodule

// ----- rtl/core/bfi_checker.sv -----
// bfi_checker: port-level assertions for the Bloom filter insert top, and its bind.
// Depends on bfi_pkg and bloom_filter_insert_crc32_top.
module bfi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_result_kind,
   input logic [bfi_pkg::CrcWidth-1:0]    rsp_hash_value,
   input logic [bfi_pkg::WordWidth-1:0]   rsp_filter_word
);
   import bfi_pkg::*;

   // read results never carry a hash
   a_read_no_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_READ) |-> (rsp_hash_value == '0))
      else $error("read result with nonzero hash_value");

   // insert results never carry filter data
   a_insert_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_INSERT) |-> (rsp_filter_word == '0))
      else $error("insert result with nonzero filter_word");

   // pipeline is empty in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_hash_value) && $stable(rsp_filter_word))
      else $error("stalled result changed");

   // input stalls only while a result is waiting downstream
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

endmodule

bind bloom_filter_insert_crc32_top bfi_checker u_bfi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_hash_value  (rsp_hash_value),
   .rsp_filter_word (rsp_filter_word)
);
